[rtl/rcsp_pkg.sv]
// shared types and constants for the command stream parser
// depends on nothing; used by rcsp_parse_core and resp_command_stream_parser
package rcsp_pkg;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam int ARG_LENGTH_W = 31;
    localparam int TDATA_W      = 80;

    typedef enum logic [1:0] {
        KIND_CMD_START = 2'd0,
        KIND_ARG_BYTE  = 2'd1,
        KIND_ARG_END   = 2'd2,
        KIND_ERROR     = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_BAD_MARKER = 2'd0,
        ERR_BAD_NUMBER = 2'd1,
        ERR_NO_CRLF    = 2'd2,
        ERR_TRUNCATED  = 2'd3
    } err_t;

    typedef enum logic [8:0] {
        PH_STAR       = 9'b000000001,
        PH_COUNT_NUM  = 9'b000000010,
        PH_COUNT_LINE = 9'b000000100,
        PH_DOLLAR     = 9'b000001000,
        PH_LEN_NUM    = 9'b000010000,
        PH_LEN_LINE   = 9'b000100000,
        PH_DATA       = 9'b001000000,
        PH_CR         = 9'b010000000,
        PH_LF         = 9'b100000000
    } phase_t;

    typedef struct packed {
        kind_t                    kind;
        logic [7:0]               byte_value;
        logic [15:0]              arg_index;
        logic [15:0]              arg_count;
        logic [ARG_LENGTH_W-1:0]  arg_length;
        logic                     final_arg;
        err_t                     error_code;
    } result_t;

endpackage

[rtl/rcsp_parse_core.sv]
// per-byte parser state and result decode for the command stream parser
// depends on rcsp_pkg; instantiated by resp_command_stream_parser
module rcsp_parse_core #(
    parameter int MAX_ARGS    = 65535,
    parameter int LENGTH_BITS = 31
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  logic [7:0]        data,
    input  logic              end_of_input,
    output logic              res_valid,
    output rcsp_pkg::result_t res,
    output logic              halted
);

    localparam int LB = LENGTH_BITS;
    localparam int VW = LENGTH_BITS + 4;

    rcsp_pkg::phase_t phase_reg, phase_next;
    logic [LB-1:0]    number_value_reg, number_value_next;
    logic             number_negative_reg, number_negative_next;
    logic             number_has_digit_reg, number_has_digit_next;
    logic             carriage_seen_reg, carriage_seen_next;
    logic [15:0]      args_total_reg, args_total_next;
    logic [15:0]      args_index_reg, args_index_next;
    logic [LB-1:0]    bytes_left_reg, bytes_left_next;
    logic [LB-1:0]    bulk_length_reg, bulk_length_next;
    logic             halted_reg, halted_next;

    logic [VW-1:0]    accum;
    logic             is_digit;
    logic             is_count;
    logic             num_bad;
    logic             num_end;
    logic             fail;
    rcsp_pkg::err_t   fail_code;
    logic [LB-1:0]    left_dec;

    assign is_digit = (data >= rcsp_pkg::CH_ZERO) && (data <= rcsp_pkg::CH_NINE);
    assign accum    = VW'({number_value_reg, 3'b000}) + VW'({number_value_reg, 1'b0})
                    + VW'(data[3:0]);
    assign is_count = (phase_reg == rcsp_pkg::PH_COUNT_NUM);
    assign left_dec = bytes_left_reg - LB'(1);

    // end of a number: validity of what was collected
    always_comb begin
        num_bad = 1'b0;
        if (!number_has_digit_reg) begin
            num_bad = 1'b1;
        end else if (number_negative_reg && (number_value_reg != '0)) begin
            num_bad = 1'b1;
        end else if (is_count && ((number_value_reg == '0)
                     || (32'(number_value_reg) > 32'(MAX_ARGS)))) begin
            num_bad = 1'b1;
        end
    end

    always_comb begin
        phase_next            = phase_reg;
        number_value_next     = number_value_reg;
        number_negative_next  = number_negative_reg;
        number_has_digit_next = number_has_digit_reg;
        carriage_seen_next    = carriage_seen_reg;
        args_total_next       = args_total_reg;
        args_index_next       = args_index_reg;
        bytes_left_next       = bytes_left_reg;
        bulk_length_next      = bulk_length_reg;
        halted_next           = halted_reg;
        fail                  = 1'b0;
        fail_code             = rcsp_pkg::ERR_BAD_MARKER;
        num_end               = 1'b0;
        res_valid             = 1'b0;
        res                   = '0;
        res.arg_index         = args_index_reg;
        res.arg_count         = args_total_reg;

        if (step && !halted_reg) begin
            unique case (phase_reg)
                rcsp_pkg::PH_STAR: begin
                    if (data != rcsp_pkg::CH_STAR) begin
                        fail = 1'b1;
                    end else begin
                        args_total_next       = '0;
                        args_index_next       = '0;
                        number_value_next     = '0;
                        number_negative_next  = 1'b0;
                        number_has_digit_next = 1'b0;
                        phase_next            = rcsp_pkg::PH_COUNT_NUM;
                    end
                end
                rcsp_pkg::PH_COUNT_NUM, rcsp_pkg::PH_LEN_NUM: begin
                    priority if (data == rcsp_pkg::CH_MINUS && !number_has_digit_reg
                                 && !number_negative_reg) begin
                        number_negative_next = 1'b1;
                    end else if (is_digit) begin
                        if (|accum[VW-1:LB]) begin
                            fail      = 1'b1;
                            fail_code = rcsp_pkg::ERR_BAD_NUMBER;
                        end else begin
                            number_value_next     = accum[LB-1:0];
                            number_has_digit_next = 1'b1;
                        end
                    end else if (num_bad) begin
                        fail      = 1'b1;
                        fail_code = rcsp_pkg::ERR_BAD_NUMBER;
                    end else begin
                        num_end = 1'b1;
                    end
                    if (num_end) begin
                        carriage_seen_next = (data == rcsp_pkg::CH_CR);
                        phase_next = is_count ? rcsp_pkg::PH_COUNT_LINE
                                              : rcsp_pkg::PH_LEN_LINE;
                    end
                end
                rcsp_pkg::PH_COUNT_LINE, rcsp_pkg::PH_LEN_LINE: begin
                    carriage_seen_next = (data == rcsp_pkg::CH_CR);
                    if (carriage_seen_reg && data == rcsp_pkg::CH_LF) begin
                        carriage_seen_next = 1'b0;
                        if (phase_reg == rcsp_pkg::PH_COUNT_LINE) begin
                            args_total_next = 16'(number_value_reg);
                            args_index_next = '0;
                            phase_next      = rcsp_pkg::PH_DOLLAR;
                            res_valid       = 1'b1;
                            res.kind        = rcsp_pkg::KIND_CMD_START;
                            res.arg_index   = '0;
                            res.arg_count   = 16'(number_value_reg);
                        end else begin
                            bulk_length_next = number_value_reg;
                            bytes_left_next  = number_value_reg;
                            phase_next = (number_value_reg != '0) ? rcsp_pkg::PH_DATA
                                                                  : rcsp_pkg::PH_CR;
                        end
                    end
                end
                rcsp_pkg::PH_DOLLAR: begin
                    if (data != rcsp_pkg::CH_DOLLAR) begin
                        fail = 1'b1;
                    end else begin
                        number_value_next     = '0;
                        number_negative_next  = 1'b0;
                        number_has_digit_next = 1'b0;
                        phase_next            = rcsp_pkg::PH_LEN_NUM;
                    end
                end
                rcsp_pkg::PH_DATA: begin
                    bytes_left_next = left_dec;
                    if (left_dec == '0) begin
                        phase_next = rcsp_pkg::PH_CR;
                    end
                    res_valid      = 1'b1;
                    res.kind       = rcsp_pkg::KIND_ARG_BYTE;
                    res.byte_value = data;
                end
                rcsp_pkg::PH_CR: begin
                    if (data != rcsp_pkg::CH_CR) begin
                        fail      = 1'b1;
                        fail_code = rcsp_pkg::ERR_NO_CRLF;
                    end else begin
                        phase_next = rcsp_pkg::PH_LF;
                    end
                end
                rcsp_pkg::PH_LF: begin
                    if (data != rcsp_pkg::CH_LF) begin
                        fail      = 1'b1;
                        fail_code = rcsp_pkg::ERR_NO_CRLF;
                    end else begin
                        res_valid      = 1'b1;
                        res.kind       = rcsp_pkg::KIND_ARG_END;
                        res.arg_length = rcsp_pkg::ARG_LENGTH_W'(bulk_length_reg);
                        if (({1'b0, args_index_reg} + 17'd1) >= {1'b0, args_total_reg}) begin
                            res.final_arg = 1'b1;
                            phase_next    = rcsp_pkg::PH_STAR;
                        end else begin
                            args_index_next = args_index_reg + 16'd1;
                            phase_next      = rcsp_pkg::PH_DOLLAR;
                        end
                    end
                end
                default: begin
                    phase_next = rcsp_pkg::PH_STAR;
                end
            endcase

            if (fail) begin
                halted_next    = 1'b1;
                res_valid      = 1'b1;
                res            = '0;
                res.kind       = rcsp_pkg::KIND_ERROR;
                res.arg_index  = args_index_reg;
                res.arg_count  = args_total_reg;
                res.error_code = fail_code;
            end else if (end_of_input && phase_next != rcsp_pkg::PH_STAR) begin
                // stream ended inside a command
                halted_next    = 1'b1;
                res_valid      = 1'b1;
                res            = '0;
                res.kind       = rcsp_pkg::KIND_ERROR;
                res.arg_index  = args_index_next;
                res.arg_count  = args_total_next;
                res.error_code = rcsp_pkg::ERR_TRUNCATED;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg            <= rcsp_pkg::PH_STAR;
            number_value_reg     <= '0;
            number_negative_reg  <= 1'b0;
            number_has_digit_reg <= 1'b0;
            carriage_seen_reg    <= 1'b0;
            args_total_reg       <= '0;
            args_index_reg       <= '0;
            bytes_left_reg       <= '0;
            bulk_length_reg      <= '0;
            halted_reg           <= 1'b0;
        end else begin
            phase_reg            <= phase_next;
            number_value_reg     <= number_value_next;
            number_negative_reg  <= number_negative_next;
            number_has_digit_reg <= number_has_digit_next;
            carriage_seen_reg    <= carriage_seen_next;
            args_total_reg       <= args_total_next;
            args_index_reg       <= args_index_next;
            bytes_left_reg       <= bytes_left_next;
            bulk_length_reg      <= bulk_length_next;
            halted_reg           <= halted_next;
        end
    end

    assign halted = halted_reg;

endmodule

[rtl/resp_command_stream_parser.sv]
// Parser for a byte stream of commands written as arrays of bulk strings.
// One byte is taken per transfer and at most one result comes out of it: a
// command start, an argument byte, an argument end or an error. The block
// sustains one byte per clock while the output side is not stalled; a byte is
// parsed while it sits in the input register and its result is then loaded
// into the result register, from which it is offered on the output. The whole
// update for a byte is one pass through the parser state in rcsp_parse_core.
// After an error the block keeps taking bytes but gives no result until reset.
// depends on rcsp_pkg and rcsp_parse_core
module resp_command_stream_parser #(
    parameter int MAX_ARGS    = 65535,
    parameter int LENGTH_BITS = 31
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // data[7:0]
    input  logic                          s_axis_tlast,  // end_of_input
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // byte_value[7:0], arg_index[23:8], arg_count[39:24], arg_length[70:40],
    // error_code[72:71], zero[79:73]
    output logic [rcsp_pkg::TDATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                    m_axis_tuser,  // kind[1:0]
    output logic                          m_axis_tlast   // final_arg
);

    logic              in_valid_reg;
    logic [7:0]        in_data_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    rcsp_pkg::result_t out_reg;
    logic              fire;
    logic              res_valid;
    rcsp_pkg::result_t res;
    logic              core_halted;

    assign fire          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || fire;

    rcsp_parse_core #(
        .MAX_ARGS    (MAX_ARGS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (fire),
        .data         (in_data_reg),
        .end_of_input (in_last_reg),
        .res_valid    (res_valid),
        .res          (res),
        .halted       (core_halted)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= res_valid;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.final_arg;
    assign m_axis_tdata  = {7'b0000000, out_reg.error_code, out_reg.arg_length,
                            out_reg.arg_count, out_reg.arg_index, out_reg.byte_value};

`ifndef SYNTHESIS
    a_error_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_valid && res.kind == rcsp_pkg::KIND_ERROR |=> core_halted)
        else $error("parser not halted after an error result");

    a_halted_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        core_halted |-> !res_valid)
        else $error("result produced while halted");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a byte before it was parsed");

    a_final_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == rcsp_pkg::KIND_ARG_END)
        else $error("final argument flag on a result that is not an argument end");
`endif

endmodule

[dv/testbench.sv]
// testbench for resp_command_stream_parser: a directed byte table, random commands
// and one closing error case, checked transfer by transfer against an in-bench parser model
// depends on rcsp_pkg and the rtl of resp_command_stream_parser
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_ARGS = 65535;
    localparam int LENGTH_BITS = 31;
    localparam longint unsigned LEN_LIMIT = (64'd1 << LENGTH_BITS) - 1;
    localparam int STIM_ITEMS = 2000;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 16;
    localparam int FAULT_CASES = 10;
    localparam rcsp_pkg::err_t NO_ERR = rcsp_pkg::ERR_BAD_MARKER;

    typedef struct {
        logic [7:0]        data;
        logic              last;
        bit                typed;
        rcsp_pkg::result_t want;
    } stim_row_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata = '0;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [rcsp_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic [1:0]                    m_axis_tuser;
    logic                          m_axis_tlast;

    stim_row_t         stim_rows[$];
    rcsp_pkg::result_t expected_events[$];
    bit        steady = 1'b0;
    int        sent_items = 0;
    int        mismatches = 0;
    int        quiet_cycles = 0;
    int        starts_seen = 0;
    int        bytes_seen = 0;
    int        ends_seen = 0;
    int        errors_seen = 0;

    // parser model state
    rcsp_pkg::phase_t ph;
    logic [30:0]  num_val;
    bit           num_neg;
    bit           num_digit;
    bit           cr_seen;
    bit           halted;
    logic [15:0]  cnt_total;
    logic [15:0]  cnt_index;
    logic [30:0]  left;
    logic [30:0]  blen;

    resp_command_stream_parser #(
        .MAX_ARGS    (MAX_ARGS),
        .LENGTH_BITS (LENGTH_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    function automatic void number_clear();
        num_val = '0;
        num_neg = 1'b0;
        num_digit = 1'b0;
    endfunction

    function automatic void parser_reset();
        ph = rcsp_pkg::PH_STAR;
        number_clear();
        cr_seen = 1'b0;
        cnt_total = '0;
        cnt_index = '0;
        left = '0;
        blen = '0;
        halted = 1'b0;
    endfunction

    function automatic rcsp_pkg::result_t make_result(rcsp_pkg::kind_t k, logic [7:0] b,
                                                      logic [30:0] len, logic fin,
                                                      rcsp_pkg::err_t code);
        rcsp_pkg::result_t r;
        r.kind = k;
        r.byte_value = b;
        r.arg_index = cnt_index;
        r.arg_count = cnt_total;
        r.arg_length = len;
        r.final_arg = fin;
        r.error_code = code;
        return r;
    endfunction

    function automatic bit fail_with(rcsp_pkg::err_t code, output rcsp_pkg::result_t r);
        halted = 1'b1;
        r = make_result(rcsp_pkg::KIND_ERROR, 8'h00, '0, 1'b0, code);
        return 1'b1;
    endfunction

    // -1 still inside the number, 0 number ended well, 1 bad number
    function automatic int number_step(logic [7:0] b, bit is_count);
        longint unsigned v;
        if (b == rcsp_pkg::CH_MINUS && !num_digit && !num_neg) begin
            num_neg = 1'b1;
            return -1;
        end
        if (b >= rcsp_pkg::CH_ZERO && b <= rcsp_pkg::CH_NINE) begin
            v = 64'(num_val) * 10 + 64'(b - rcsp_pkg::CH_ZERO);
            if (v > LEN_LIMIT) return 1;
            num_val = v[30:0];
            num_digit = 1'b1;
            return -1;
        end
        if (!num_digit) return 1;
        if (num_neg && num_val != 0) return 1;
        if (is_count && (num_val == 0 || num_val > MAX_ARGS)) return 1;
        cr_seen = (b == rcsp_pkg::CH_CR);
        return 0;
    endfunction

    function automatic bit parse_step(logic [7:0] b, output rcsp_pkg::result_t r);
        int nr;
        bit crlf_hit;
        r = '0;
        case (ph)
            rcsp_pkg::PH_STAR: begin
                if (b != rcsp_pkg::CH_STAR) return fail_with(rcsp_pkg::ERR_BAD_MARKER, r);
                cnt_total = '0;
                cnt_index = '0;
                number_clear();
                ph = rcsp_pkg::PH_COUNT_NUM;
                return 1'b0;
            end
            rcsp_pkg::PH_COUNT_NUM, rcsp_pkg::PH_LEN_NUM: begin
                nr = number_step(b, ph == rcsp_pkg::PH_COUNT_NUM);
                if (nr > 0) return fail_with(rcsp_pkg::ERR_BAD_NUMBER, r);
                if (nr == 0) ph = (ph == rcsp_pkg::PH_COUNT_NUM) ? rcsp_pkg::PH_COUNT_LINE
                                                                 : rcsp_pkg::PH_LEN_LINE;
                return 1'b0;
            end
            rcsp_pkg::PH_COUNT_LINE, rcsp_pkg::PH_LEN_LINE: begin
                crlf_hit = cr_seen && b == rcsp_pkg::CH_LF;
                cr_seen = (b == rcsp_pkg::CH_CR);
                if (!crlf_hit) return 1'b0;
                cr_seen = 1'b0;
                if (ph == rcsp_pkg::PH_COUNT_LINE) begin
                    cnt_total = num_val[15:0];
                    cnt_index = '0;
                    ph = rcsp_pkg::PH_DOLLAR;
                    r = make_result(rcsp_pkg::KIND_CMD_START, 8'h00, '0, 1'b0, NO_ERR);
                    return 1'b1;
                end
                blen = num_val;
                left = num_val;
                ph = (left != 0) ? rcsp_pkg::PH_DATA : rcsp_pkg::PH_CR;
                return 1'b0;
            end
            rcsp_pkg::PH_DOLLAR: begin
                if (b != rcsp_pkg::CH_DOLLAR) return fail_with(rcsp_pkg::ERR_BAD_MARKER, r);
                number_clear();
                ph = rcsp_pkg::PH_LEN_NUM;
                return 1'b0;
            end
            rcsp_pkg::PH_DATA: begin
                left = left - 31'd1;
                if (left == 0) ph = rcsp_pkg::PH_CR;
                r = make_result(rcsp_pkg::KIND_ARG_BYTE, b, '0, 1'b0, NO_ERR);
                return 1'b1;
            end
            rcsp_pkg::PH_CR: begin
                if (b != rcsp_pkg::CH_CR) return fail_with(rcsp_pkg::ERR_NO_CRLF, r);
                ph = rcsp_pkg::PH_LF;
                return 1'b0;
            end
            default: begin
                if (b != rcsp_pkg::CH_LF) return fail_with(rcsp_pkg::ERR_NO_CRLF, r);
                if (int'(cnt_index) + 1 >= int'(cnt_total)) begin
                    r = make_result(rcsp_pkg::KIND_ARG_END, 8'h00, blen, 1'b1, NO_ERR);
                    ph = rcsp_pkg::PH_STAR;
                end else begin
                    r = make_result(rcsp_pkg::KIND_ARG_END, 8'h00, blen, 1'b0, NO_ERR);
                    cnt_index = cnt_index + 16'd1;
                    ph = rcsp_pkg::PH_DOLLAR;
                end
                return 1'b1;
            end
        endcase
    endfunction

    function automatic bit parser_accept(logic [7:0] b, logic last,
                                         output rcsp_pkg::result_t r);
        bit got;
        r = '0;
        if (halted) return 1'b0;
        got = parse_step(b, r);
        if (halted) return got;
        // end mark inside a command turns this byte's result into truncation
        if (last && ph != rcsp_pkg::PH_STAR) return fail_with(rcsp_pkg::ERR_TRUNCATED, r);
        return got;
    endfunction

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 60) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic add_byte(logic [7:0] b, logic last);
        stim_rows.push_back('{data: b, last: last, typed: 1'b0, want: '0});
    endtask

    task automatic add_typed(logic [7:0] b, logic last, rcsp_pkg::result_t want);
        stim_rows.push_back('{data: b, last: last, typed: 1'b1, want: want});
    endtask

    task automatic add_text(string s);
        for (int k = 0; k < s.len(); k++) add_byte(s[k], 1'b0);
    endtask

    task automatic add_number(int unsigned value, bit with_minus);
        string digits;
        if (with_minus) add_byte(rcsp_pkg::CH_MINUS, 1'b0);
        if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 2)) add_byte(rcsp_pkg::CH_ZERO, 1'b0);
        digits = $sformatf("%0d", value);
        add_text(digits);
    endtask

    // optional junk after a number, then the line end
    task automatic add_line_tail();
        logic [7:0] b;
        logic [7:0] prev;
        int n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        prev = 8'h00;
        for (int k = 0; k < n; k++) begin
            b = 8'($urandom_range(0, 255));
            if (k == 0 && b >= rcsp_pkg::CH_ZERO && b <= rcsp_pkg::CH_NINE)
                b = rcsp_pkg::CH_MINUS;
            if (prev == rcsp_pkg::CH_CR && b == rcsp_pkg::CH_LF) b = rcsp_pkg::CH_CR;
            add_byte(b, 1'b0);
            prev = b;
        end
        add_byte(rcsp_pkg::CH_CR, 1'b0);
        add_byte(rcsp_pkg::CH_LF, 1'b0);
    endtask

    task automatic add_command(int nargs, bit mark_end);
        int len;
        int p;
        add_byte(rcsp_pkg::CH_STAR, 1'b0);
        add_number(nargs, 1'b0);
        add_line_tail();
        for (int a = 0; a < nargs; a++) begin
            p = $urandom_range(0, 99);
            if (p < 10) len = 0;
            else if (p < 85) len = $urandom_range(1, 8);
            else if (p < 98) len = $urandom_range(9, 40);
            else len = $urandom_range(100, 300);
            add_byte(rcsp_pkg::CH_DOLLAR, 1'b0);
            add_number(len, len == 0 && $urandom_range(0, 1) == 1);
            add_line_tail();
            repeat (len) add_byte(8'($urandom_range(0, 255)), 1'b0);
            add_byte(rcsp_pkg::CH_CR, 1'b0);
            add_byte(rcsp_pkg::CH_LF, mark_end && a == nargs - 1);
        end
    endtask

    // the parser halts on its first error, so each run closes with one error case
    task automatic add_fault(int which);
        logic [7:0] b;
        int cut;
        string bad_counts[7] = '{"0", "-0", "-7", "65536", "", "-", "--"};
        case (which)
            0: begin
                do b = 8'($urandom_range(0, 255)); while (b == rcsp_pkg::CH_STAR);
                add_byte(b, 1'b0);
            end
            1: begin
                add_text("*3\r\n");
                do b = 8'($urandom_range(0, 255)); while (b == rcsp_pkg::CH_DOLLAR);
                add_byte(b, 1'b0);
            end
            2: begin
                add_byte(rcsp_pkg::CH_STAR, 1'b0);
                add_text(bad_counts[$urandom_range(0, 6)]);
                add_text("\r\n");
            end
            3: begin
                if ($urandom_range(0, 1) == 1) add_text("*99999999999\r\n");
                else add_text("*1\r\n$2147483648\r\n");
            end
            4: begin
                if ($urandom_range(0, 1) == 1) add_text("*1\r\n$-3\r\n");
                else add_text("*1\r\n$x\r\n");
            end
            5: begin
                add_text("*1\r\n$2\r\nab");
                do b = 8'($urandom_range(0, 255)); while (b == rcsp_pkg::CH_CR);
                add_byte(b, 1'b0);
            end
            6: begin
                add_text("*1\r\n$2\r\nab\r");
                do b = 8'($urandom_range(0, 255)); while (b == rcsp_pkg::CH_LF);
                add_byte(b, 1'b0);
            end
            7: begin
                add_command($urandom_range(1, 4), 1'b0);
                cut = $urandom_range(0, stim_rows.size() - 2);
                stim_rows = stim_rows[0:cut];
                stim_rows[cut].last = 1'b1;
            end
            8: begin
                add_text("*65535\r\n$2147483647\r\n");
                repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)), 1'b0);
                add_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            default: begin
                add_text("*1\r\n");
                do b = 8'($urandom_range(0, 255)); while (b == rcsp_pkg::CH_DOLLAR);
                add_byte(b, 1'b1);
            end
        endcase
        // ignored once halted
        repeat (20) add_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_row(stim_row_t row);
        rcsp_pkg::result_t want;
        bit got;
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= row.data;
        s_axis_tlast <= row.last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sent_items++;
        got = parser_accept(row.data, row.last, want);
        if (row.typed) expected_events.push_back(row.want);
        else if (got) expected_events.push_back(want);
    endtask

    task automatic flush_rows();
        foreach (stim_rows[k]) send_row(stim_rows[k]);
        stim_rows.delete();
    endtask

    task automatic wait_drained();
        while (expected_events.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int stall;
        forever begin
            stall = gap_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : result_check
        rcsp_pkg::result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            case (rcsp_pkg::kind_t'(m_axis_tuser))
                rcsp_pkg::KIND_CMD_START: starts_seen++;
                rcsp_pkg::KIND_ARG_BYTE:  bytes_seen++;
                rcsp_pkg::KIND_ARG_END:   ends_seen++;
                default:                  errors_seen++;
            endcase
            if (expected_events.size() == 0) begin
                $error("result with nothing expected: kind %0d tdata %0h",
                       m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_events.pop_front();
                check_field("kind", 64'(want.kind), 64'(m_axis_tuser));
                check_field("byte_value", 64'(want.byte_value), 64'(m_axis_tdata[7:0]));
                check_field("arg_index", 64'(want.arg_index), 64'(m_axis_tdata[23:8]));
                check_field("arg_count", 64'(want.arg_count), 64'(m_axis_tdata[39:24]));
                check_field("arg_length", 64'(want.arg_length), 64'(m_axis_tdata[70:40]));
                check_field("error_code", 64'(want.error_code), 64'(m_axis_tdata[72:71]));
                check_field("tdata padding", 64'd0, 64'(m_axis_tdata[79:73]));
                check_field("final_arg", 64'(want.final_arg), 64'(m_axis_tlast));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $error("no transfer for %0d cycles, %0d results outstanding",
                   quiet_cycles, expected_events.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin
        int fault_kind;
        parser_reset();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // one argument of length minus zero, end mark at a command boundary
        add_text("*1\r");
        add_typed(rcsp_pkg::CH_LF, 1'b0, '{rcsp_pkg::KIND_CMD_START, 8'h00, 16'd0, 16'd1,
                                           31'd0, 1'b0, NO_ERR});
        add_text("$-0\r\n\r");
        add_typed(rcsp_pkg::CH_LF, 1'b1, '{rcsp_pkg::KIND_ARG_END, 8'h00, 16'd0, 16'd1,
                                           31'd0, 1'b1, NO_ERR});
        // leading zero, junk header tail with a stray cr, data byte extremes
        add_text("*02-\r\r\n$1\r\n");
        add_typed(8'hFF, 1'b0, '{rcsp_pkg::KIND_ARG_BYTE, 8'hFF, 16'd0, 16'd2,
                                 31'd0, 1'b0, NO_ERR});
        add_text("\r\n$1\r\n");
        add_typed(8'h00, 1'b0, '{rcsp_pkg::KIND_ARG_BYTE, 8'h00, 16'd1, 16'd2,
                                 31'd0, 1'b0, NO_ERR});
        add_text("\r\n");
        flush_rows();
        s_axis_tvalid <= 1'b0;
        wait_drained();

        while (sent_items < STIM_ITEMS) begin
            if ($urandom_range(0, 14) == 0) steady = !steady;
            if ($urandom_range(0, 99) < 85) add_command($urandom_range(1, 4),
                                                        $urandom_range(0, 7) == 0);
            else add_command($urandom_range(5, 12), $urandom_range(0, 7) == 0);
            flush_rows();
            if ($urandom_range(0, 24) == 0) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
        end

        steady = 1'b0;
        fault_kind = $urandom_range(0, FAULT_CASES - 1);
        add_fault(fault_kind);
        flush_rows();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d input bytes: %0d commands, %0d argument bytes, %0d argument ends",
                 sent_items, starts_seen, bytes_seen, ends_seen);
        $display("closing error case %0d, %0d error results, %0d mismatches",
                 fault_kind, errors_seen, mismatches);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/rcsp_pkg.sv
rtl/rcsp_parse_core.sv
rtl/resp_command_stream_parser.sv
dv/testbench.sv
